// ===== rtl/core/flzb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package flzb_pkg;

    localparam int DEF_MAX_WIDTH  = 320;
    localparam int DEF_MAX_HEIGHT = 240;

    // configuration register indexes
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_VAR_GAIN     = 2'd2;
    localparam logic [1:0] CFG_VAR_FLOOR    = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 48;

    localparam logic [8:0]  RST_FRAME_WIDTH  = 9'd320;
    localparam logic [7:0]  RST_FRAME_HEIGHT = 8'd240;
    localparam logic [15:0] RST_VAR_GAIN     = 16'd16384;
    localparam logic [23:0] RST_VAR_FLOOR    = 24'd0;

    localparam logic [23:0] VAR_MAX = 24'hFFFFFF;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic        var_valid;
        logic [23:0] var_val;
        logic        depth_valid;
        logic [15:0] depth;
    } t_entry;

endpackage

`default_nettype wire

// ===== rtl/core/flow_depth_splat_zbuffer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  | dir | handshake              | payload
// s_axis   | in  | s_axis_tvalid / tready | tuser: cmd; tdata: splat or read command
// m_axis   | out | m_axis_tvalid / tready | tdata: read pixel; tlast: last_pixel
// cfg      | in  | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// one word per cycle unless output stalls; read results pass s1, s2 and output registers.
// the pace is set by the two-port read-modify-write on the pixel store (one read
// and one write per cycle), with forwarding from the write stage to the read stage.
// after reset a clearing pass writes every store entry, MAX_WIDTH*MAX_HEIGHT of them
// (76800 at the defaults), during which s_axis_tready stays low.
// a full output register that is not taken freezes the whole pipeline.
module flow_depth_splat_zbuffer #(
    parameter int MAX_WIDTH  = flzb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = flzb_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // slave side
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // src_x[8:0], src_y[16:9], depth_in[32:17], depth_ok[33], variance_in[57:34],
    // variance_ok[58], flow_x[74:59], flow_y[90:75], zero fill above
    input  wire logic [flzb_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // cmd[0]
    input  wire logic                             s_axis_tuser,
    // master side
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // out_depth[15:0], out_depth_valid[16], out_variance[40:17],
    // out_variance_valid[41], zero fill above
    output logic [flzb_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // last_pixel
    output logic                                  m_axis_tlast,
    // configuration
    input  wire logic                             i_cfg_we,
    input  wire logic [flzb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [flzb_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import flzb_pkg::*;

    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int CAP_W = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
    localparam int CAP_H = (MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT;
    localparam logic [8:0] CAP_W9 = 9'(CAP_W);
    localparam logic [7:0] CAP_H8 = 8'(CAP_H);
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_SIZE - 1);
    localparam logic [AW-1:0] ROW_STEP  = AW'(MAX_WIDTH);

    // configuration
    logic [8:0]  r_frame_width;
    logic [7:0]  r_frame_height;
    logic [15:0] r_var_gain;
    logic [23:0] r_var_floor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_var_gain     <= RST_VAR_GAIN;
            r_var_floor    <= RST_VAR_FLOOR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[8:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[7:0];
                CFG_VAR_GAIN:     r_var_gain     <= i_cfg_data[15:0];
                CFG_VAR_FLOOR:    r_var_floor    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [8:0] eff_w;
    logic [7:0] eff_h;

    always_comb begin
        if (r_frame_width == '0) begin
            eff_w = 9'd1;
        end else if (r_frame_width > CAP_W9) begin
            eff_w = CAP_W9;
        end else begin
            eff_w = r_frame_width;
        end
        if (r_frame_height == '0) begin
            eff_h = 8'd1;
        end else if (r_frame_height > CAP_H8) begin
            eff_h = CAP_H8;
        end else begin
            eff_h = r_frame_height;
        end
    end

    // state machine: clearing pass, then run
    t_state        r_state, n_state;
    logic [AW-1:0] r_clr_addr;
    logic          clr_done;

    assign clr_done = (r_clr_addr == LAST_ADDR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (clr_done) n_state = ST_RUN;
            ST_RUN:   n_state = ST_RUN;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // pipeline enable: everything advances unless a result waits unclaimed
    logic r_out_valid;
    logic en;
    logic accept;

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en && (r_state == ST_RUN);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // stage 0: field unpack, warp, readout counters
    logic [8:0]  in_src_x;
    logic [7:0]  in_src_y;
    logic [15:0] in_depth;
    logic        in_depth_ok;
    logic [23:0] in_var;
    logic        in_var_ok;
    logic [15:0] in_flow_x;
    logic [15:0] in_flow_y;

    assign in_src_x    = s_axis_tdata[8:0];
    assign in_src_y    = s_axis_tdata[16:9];
    assign in_depth    = s_axis_tdata[32:17];
    assign in_depth_ok = s_axis_tdata[33];
    assign in_var      = s_axis_tdata[57:34];
    assign in_var_ok   = s_axis_tdata[58];
    assign in_flow_x   = s_axis_tdata[74:59];
    assign in_flow_y   = s_axis_tdata[90:75];

    logic signed [17:0] sum_x, sum_y, rnd_x, rnd_y;
    logic signed [11:0] tgt_x, tgt_y;
    logic               tgt_in;

    always_comb begin
        sum_x = $signed({3'b000, in_src_x, 6'b000000}) + $signed({{2{in_flow_x[15]}}, in_flow_x});
        sum_y = $signed({4'b0000, in_src_y, 6'b000000}) + $signed({{2{in_flow_y[15]}}, in_flow_y});
        // half away from zero: +32 then floor when positive, +31 then floor when negative
        rnd_x = sum_x + (sum_x[17] ? 18'sd31 : 18'sd32);
        rnd_y = sum_y + (sum_y[17] ? 18'sd31 : 18'sd32);
        tgt_x = rnd_x[17:6];
        tgt_y = rnd_y[17:6];
        tgt_in = !tgt_x[11] && !tgt_y[11]
              && (tgt_x[10:0] < {2'b00, eff_w})
              && (tgt_y[10:0] < {3'b000, eff_h});
    end

    logic [8:0] r_col, n_col, cur_col;
    logic [7:0] r_row, n_row, cur_row;
    logic       cur_last;

    always_comb begin
        if ((r_col >= eff_w) || (r_row >= eff_h)) begin
            cur_col = '0;
            cur_row = '0;
        end else begin
            cur_col = r_col;
            cur_row = r_row;
        end
        cur_last = (cur_col == eff_w - 9'd1) && (cur_row == eff_h - 8'd1);
        n_col = cur_col + 9'd1;
        n_row = cur_row;
        if ({1'b0, cur_col} + 10'd1 >= {1'b0, eff_w}) begin
            n_col = '0;
            n_row = ({1'b0, cur_row} + 9'd1 >= {1'b0, eff_h}) ? 8'd0 : cur_row + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept && s_axis_tuser) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage 1 registers
    logic        r_s1_valid;
    logic        r_s1_read;
    logic [8:0]  r_s1_x;
    logic [7:0]  r_s1_y;
    logic        r_s1_ok;
    logic [15:0] r_s1_depth;
    logic        r_s1_vok;
    logic [39:0] r_s1_prod;
    logic        r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_read  <= s_axis_tuser;
            r_s1_x     <= s_axis_tuser ? cur_col : tgt_x[8:0];
            r_s1_y     <= s_axis_tuser ? cur_row : tgt_y[7:0];
            r_s1_ok    <= tgt_in && in_depth_ok && (in_depth != '0);
            r_s1_depth <= in_depth;
            r_s1_vok   <= in_var_ok;
            r_s1_prod  <= 40'(in_var) * 40'(r_var_gain);
            r_s1_last  <= cur_last;
        end
    end

    // stage 1: address, variance scaling, memory read
    logic [AW-1:0] s1_addr;
    logic [40:0]   s1_rnd;
    logic [27:0]   s1_sum;
    logic [23:0]   s1_var;

    always_comb begin
        s1_addr = AW'(AW'(r_s1_y) * ROW_STEP + AW'(r_s1_x));
        s1_rnd  = {1'b0, r_s1_prod} + 41'd8192;
        s1_sum  = {1'b0, s1_rnd[40:14]} + {4'b0000, r_var_floor};
        s1_var  = (s1_sum > {4'b0000, VAR_MAX}) ? VAR_MAX : s1_sum[23:0];
    end

    // stage 2 registers
    logic          r_s2_valid;
    logic          r_s2_read;
    logic [AW-1:0] r_s2_addr;
    logic          r_s2_ok;
    logic [15:0]   r_s2_depth;
    logic          r_s2_vok;
    logic [23:0]   r_s2_var;
    logic          r_s2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_read  <= r_s1_read;
            r_s2_addr  <= s1_addr;
            r_s2_ok    <= r_s1_ok;
            r_s2_depth <= r_s1_depth;
            r_s2_vok   <= r_s1_vok;
            r_s2_var   <= s1_var;
            r_s2_last  <= r_s1_last;
        end
    end

    // pixel store
    t_entry        r_mem [STORE_SIZE];
    t_entry        r_rd_data;
    t_entry        r_fwd_data;
    logic          r_fwd_hit;
    t_entry        s2_cur;
    t_entry        s2_wdata;
    logic          s2_we;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;

    always_comb begin
        s2_cur = r_fwd_hit ? r_fwd_data : r_rd_data;
        s2_wdata = '0;
        s2_we = 1'b0;
        if (r_s2_valid) begin
            if (r_s2_read) begin
                s2_we = 1'b1;
            end else if (r_s2_ok && (!s2_cur.depth_valid || (r_s2_depth < s2_cur.depth))) begin
                s2_we = 1'b1;
                s2_wdata.depth_valid = 1'b1;
                s2_wdata.depth       = r_s2_depth;
                s2_wdata.var_valid   = r_s2_vok ? 1'b1 : s2_cur.var_valid;
                s2_wdata.var_val     = r_s2_vok ? r_s2_var : s2_cur.var_val;
            end
        end
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = en && s2_we;
            mem_waddr = r_s2_addr;
            mem_wdata = s2_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rd_data <= r_mem[s1_addr];
        end
    end

    // the write of this edge is missed by the read of the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (en) begin
            r_fwd_hit <= s2_we && (s1_addr == r_s2_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fwd_data <= s2_wdata;
        end
    end

    // output register
    logic [15:0] r_out_depth;
    logic        r_out_depth_valid;
    logic [23:0] r_out_var;
    logic        r_out_var_valid;
    logic        r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s2_valid && r_s2_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_depth       <= s2_cur.depth_valid ? s2_cur.depth : 16'd0;
            r_out_depth_valid <= s2_cur.depth_valid;
            r_out_var         <= s2_cur.var_valid ? s2_cur.var_val : 24'd0;
            r_out_var_valid   <= s2_cur.var_valid;
            r_out_last        <= r_s2_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b000000, r_out_var_valid, r_out_var, r_out_depth_valid, r_out_depth};
    assign m_axis_tlast  = r_out_last;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !s_axis_tready)
        else $error("word accepted during clearing pass");

    a_stall_freezes_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> $stable(r_s1_valid) && $stable(r_s2_valid))
        else $error("pipeline moved while output stalled");

    a_empty_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_depth_valid) |-> (r_out_depth == 16'd0))
        else $error("empty pixel with nonzero depth");

    a_write_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_s2_valid && r_s2_read && (r_state == ST_RUN)) |-> (mem_we && (mem_wdata == '0)))
        else $error("read pixel not cleared");

endmodule

`default_nettype wire

// ===== verif/flow_depth_splat_zbuffer_tb.sv =====
`timescale 1ns / 1ps

module flow_depth_splat_zbuffer_tb;
    import flzb_pkg::*;

    localparam int MAXW = DEF_MAX_WIDTH;
    localparam int MAXH = DEF_MAX_HEIGHT;
    localparam int NPIX = MAXW * MAXH;
    localparam int SETTLE_CYCLES = 8;
    // the clearing pass after reset alone spans all 76800 store entries with no traffic
    localparam int QUIET_LIMIT = 250000;
    localparam int HOLD_CYCLES = 400;

    localparam logic CMD_SPLAT = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef struct packed {
        logic [15:0] depth;
        logic        depth_ok;
        logic [23:0] variance;
        logic        variance_ok;
        logic        last;
    } t_pixel;

    typedef struct {
        bit     typed;
        t_pixel px;
    } t_read_note;

    typedef enum logic [1:0] {
        ROW_SPLAT,
        ROW_READ,
        ROW_REG
    } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [95:0] word;
        logic [1:0]  reg_idx;
        logic [23:0] reg_val;
        t_read_note  note;
    } t_plan_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    flow_depth_splat_zbuffer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // mirror of the z-buffer and its registers
    logic [16:0] zbuf_depth [NPIX];
    logic [24:0] zbuf_var [NPIX];
    int          rd_col = 0;
    int          rd_row = 0;
    logic [8:0]  cfg_width = RST_FRAME_WIDTH;
    logic [7:0]  cfg_height = RST_FRAME_HEIGHT;
    logic [15:0] cfg_gain = RST_VAR_GAIN;
    logic [23:0] cfg_floor = RST_VAR_FLOOR;

    t_pixel     pending_pixels [$];
    t_read_note read_notes [$];
    t_plan_row  plan [$];

    int fail_cnt = 0;
    int splat_cnt = 0;
    int read_cnt = 0;
    int pixel_cnt = 0;
    int last_cnt = 0;
    int items_sent = 0;
    int src_idle_pct = 8;
    int sink_idle_pct = 46;
    int quiet_cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    initial begin
        for (int i = 0; i < NPIX; i++) begin
            zbuf_depth[i] = '0;
            zbuf_var[i] = '0;
        end
    end

    function automatic int active_width();
        if (cfg_width == 0) return 1;
        return (cfg_width > MAXW) ? MAXW : int'(cfg_width);
    endfunction

    function automatic int active_height();
        if (cfg_height == 0) return 1;
        return (cfg_height > MAXH) ? MAXH : int'(cfg_height);
    endfunction

    // position plus q10.6 flow, halves away from zero
    function automatic int warp_pos(input int pos, input logic signed [15:0] flow);
        int t;
        t = pos * 64 + flow;
        if (t >= 0) return (t + 32) / 64;
        return -((-t + 32) / 64);
    endfunction

    function automatic void splat_into_zbuf(input logic [95:0] w);
        int tx, ty, idx;
        logic [63:0] grown;
        tx = warp_pos(int'(w[8:0]), w[74:59]);
        ty = warp_pos(int'(w[16:9]), w[90:75]);
        if (tx < 0 || ty < 0 || tx >= active_width() || ty >= active_height()) return;
        if (!w[33] || w[32:17] == 16'd0) return;
        idx = ty * MAXW + tx;
        if (zbuf_depth[idx][16] && w[32:17] >= zbuf_depth[idx][15:0]) return;
        zbuf_depth[idx] = {1'b1, w[32:17]};
        if (w[58]) begin
            grown = (64'(w[57:34]) * 64'(cfg_gain) + 64'd8192) >> 14;
            grown = grown + 64'(cfg_floor);
            if (grown > 64'(VAR_MAX)) grown = 64'(VAR_MAX);
            zbuf_var[idx] = {1'b1, grown[23:0]};
        end
    endfunction

    function automatic t_pixel read_out_pixel();
        t_pixel p;
        int idx;
        if (rd_col >= active_width() || rd_row >= active_height()) begin
            rd_col = 0;
            rd_row = 0;
        end
        idx = rd_row * MAXW + rd_col;
        p.depth       = zbuf_depth[idx][16] ? zbuf_depth[idx][15:0] : 16'd0;
        p.depth_ok    = zbuf_depth[idx][16];
        p.variance    = zbuf_var[idx][24] ? zbuf_var[idx][23:0] : 24'd0;
        p.variance_ok = zbuf_var[idx][24];
        p.last        = (rd_col == active_width() - 1) && (rd_row == active_height() - 1);
        zbuf_depth[idx] = '0;
        zbuf_var[idx] = '0;
        rd_col++;
        if (rd_col >= active_width()) begin
            rd_col = 0;
            rd_row++;
            if (rd_row >= active_height()) rd_row = 0;
        end
        return p;
    endfunction

    function automatic void diff(input string name, input logic [23:0] want,
                                 input logic [23:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_cnt++;
        end
    endfunction

    function automatic logic [95:0] splat_word(input logic [8:0] sx, input logic [7:0] sy,
                                               input logic [15:0] dep, input logic dok,
                                               input logic [23:0] vin, input logic vok,
                                               input logic [15:0] fx, input logic [15:0] fy);
        return {5'd0, fy, fx, vok, vin, dok, dep, sy, sx};
    endfunction

    // prediction on every accepted word, checking on every accepted pixel
    always @(posedge i_clk) begin : monitor
        t_pixel got, want;
        t_read_note note;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FRAME_WIDTH:  cfg_width = i_cfg_data[8:0];
                    CFG_FRAME_HEIGHT: cfg_height = i_cfg_data[7:0];
                    CFG_VAR_GAIN:     cfg_gain = i_cfg_data[15:0];
                    CFG_VAR_FLOOR:    cfg_floor = i_cfg_data[23:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == CMD_READ) begin
                    want = read_out_pixel();
                    note = read_notes.pop_front();
                    pending_pixels.push_back(note.typed ? note.px : want);
                    read_cnt++;
                end else begin
                    splat_into_zbuf(s_axis_tdata);
                    splat_cnt++;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.depth       = m_axis_tdata[15:0];
                got.depth_ok    = m_axis_tdata[16];
                got.variance    = m_axis_tdata[40:17];
                got.variance_ok = m_axis_tdata[41];
                got.last        = m_axis_tlast;
                pixel_cnt++;
                if (got.last) last_cnt++;
                if (pending_pixels.size() == 0) begin
                    $error("pixel word with nothing pending: %h", m_axis_tdata);
                    fail_cnt++;
                end else begin
                    want = pending_pixels.pop_front();
                    diff("out_depth", 24'(want.depth), 24'(got.depth));
                    diff("out_depth_valid", 24'(want.depth_ok), 24'(got.depth_ok));
                    diff("out_variance", want.variance, got.variance);
                    diff("out_variance_valid", 24'(want.variance_ok), 24'(got.variance_ok));
                    diff("last_pixel", 24'(want.last), 24'(got.last));
                end
            end
        end
    end

    // sink: random stalls, plus one long hold-off so the pipeline fills
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && pixel_cnt >= 150) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_word(input logic cmd, input logic [95:0] word);
        if (items_sent < 350) begin
            src_idle_pct = 8;
            sink_idle_pct = 46;
        end else if (items_sent < 700) begin
            src_idle_pct = 46;
            sink_idle_pct = 8;
        end else begin
            src_idle_pct = 0;
            sink_idle_pct = 0;
        end
        if ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= word;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // wait for every pending pixel, then let in-flight splats retire
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic add_splat(input logic [8:0] sx, input logic [7:0] sy,
                             input logic [15:0] dep, input logic dok,
                             input logic [23:0] vin, input logic vok,
                             input logic [15:0] fx, input logic [15:0] fy);
        t_plan_row r;
        r.kind = ROW_SPLAT;
        r.word = splat_word(sx, sy, dep, dok, vin, vok, fx, fy);
        r.reg_idx = '0;
        r.reg_val = '0;
        r.note.typed = 1'b0;
        r.note.px = '0;
        plan.push_back(r);
    endtask

    task automatic add_read(input bit typed, input logic [15:0] dep, input logic dok,
                            input logic [23:0] vin, input logic vok, input logic last);
        t_plan_row r;
        r.kind = ROW_READ;
        r.word = '0;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.note.typed = typed;
        r.note.px = {dep, dok, vin, vok, last};
        plan.push_back(r);
    endtask

    task automatic add_reg(input logic [1:0] idx, input logic [23:0] val);
        t_plan_row r;
        r.kind = ROW_REG;
        r.word = '0;
        r.reg_idx = idx;
        r.reg_val = val;
        r.note.typed = 1'b0;
        r.note.px = '0;
        plan.push_back(r);
    endtask

    task automatic run_phase(input logic [8:0] w_reg, input logic [7:0] h_reg,
                             input logic [15:0] gain, input logic [23:0] vfloor,
                             input int n, input int read_pct);
        logic [23:0] d;
        logic [95:0] noise;
        logic [8:0]  sx;
        logic [7:0]  sy;
        logic [15:0] dep, fx, fy;
        logic [23:0] vin;
        logic        dok, vok;
        int          aw, ah;
        t_read_note  note;
        settle();
        // upper data bits beyond each register are don't-care
        d = 24'($urandom);
        d[8:0] = w_reg;
        write_reg(CFG_FRAME_WIDTH, d);
        d = 24'($urandom);
        d[7:0] = h_reg;
        write_reg(CFG_FRAME_HEIGHT, d);
        d = 24'($urandom);
        d[15:0] = gain;
        write_reg(CFG_VAR_GAIN, d);
        write_reg(CFG_VAR_FLOOR, vfloor);
        aw = (w_reg == 0) ? 1 : ((w_reg > MAXW) ? MAXW : int'(w_reg));
        ah = (h_reg == 0) ? 1 : ((h_reg > MAXH) ? MAXH : int'(h_reg));
        note.typed = 1'b0;
        note.px = '0;
        repeat (n) begin
            if ($urandom_range(99) < read_pct) begin
                noise = {$urandom, $urandom, $urandom};
                noise[95:91] = '0;
                read_notes.push_back(note);
                push_word(CMD_READ, noise);
            end else begin
                if ($urandom_range(99) < 80) begin
                    // aimed into the frame, up to one and a half pixels of flow
                    sx = 9'($urandom_range(0, aw - 1));
                    sy = 8'($urandom_range(0, ah - 1));
                    fx = 16'($urandom_range(0, 192) - 96);
                    fy = 16'($urandom_range(0, 192) - 96);
                end else begin
                    sx = 9'($urandom);
                    sy = 8'($urandom);
                    fx = 16'($urandom);
                    fy = 16'($urandom);
                end
                // narrow depths make ties and zero depths common
                dep = ($urandom_range(1) == 0) ? 16'($urandom_range(0, 6)) : 16'($urandom);
                dok = ($urandom_range(9) != 0);
                vin = 24'($urandom);
                vok = ($urandom_range(3) != 0);
                push_word(CMD_SPLAT, splat_word(sx, sy, dep, dok, vin, vok, fx, fy));
            end
        end
    endtask

    initial begin : stimulus
        t_plan_row r;
        // 320x240 right after reset: empty pixel, then z-test on (1,0) and (2,0)
        add_read(1'b1, 16'd0, 1'b0, 24'd0, 1'b0, 1'b0);
        add_splat(9'd1, 8'd0, 16'h0100, 1'b1, 24'h010000, 1'b1, 16'd0, 16'd0);
        add_splat(9'd1, 8'd0, 16'h0200, 1'b1, 24'h020000, 1'b1, 16'd0, 16'd0);
        add_splat(9'd0, 8'd0, 16'h0080, 1'b1, 24'hFFFFFF, 1'b0, 16'd32, 16'd0);
        add_splat(9'd1, 8'd0, 16'h0001, 1'b0, 24'h000005, 1'b1, 16'd0, 16'd0);
        add_splat(9'd1, 8'd0, 16'h0000, 1'b1, 24'h000005, 1'b1, 16'd0, 16'd0);
        add_splat(9'd0, 8'd0, 16'h0001, 1'b1, 24'h000005, 1'b1, -16'sd32, 16'd0);
        add_splat(9'd319, 8'd239, 16'hFFFF, 1'b1, 24'hFFFFFF, 1'b1, 16'h8000, 16'h8000);
        add_splat(9'd0, 8'd0, 16'hFFFF, 1'b1, 24'hFFFFFF, 1'b1, 16'h7FFF, 16'h7FFF);
        add_splat(9'd2, 8'd0, 16'hFFFF, 1'b1, 24'hFFFFFF, 1'b1, -16'sd32, 16'd0);
        add_splat(9'd3, 8'd0, 16'hFFFE, 1'b1, 24'h000001, 1'b1, -16'sd33, 16'd0);
        add_read(1'b0, 16'd0, 1'b0, 24'd0, 1'b0, 1'b0);
        add_read(1'b0, 16'd0, 1'b0, 24'd0, 1'b0, 1'b0);
        add_read(1'b1, 16'd0, 1'b0, 24'd0, 1'b0, 1'b0);
        // zero size acts as 1x1, readout counters fall outside and restart
        add_reg(CFG_FRAME_WIDTH, 24'd0);
        add_reg(CFG_FRAME_HEIGHT, 24'd0);
        add_splat(9'd0, 8'd0, 16'h1234, 1'b1, 24'h123456, 1'b1, 16'd0, 16'd0);
        add_read(1'b1, 16'h1234, 1'b1, 24'h123456, 1'b1, 1'b1);
        add_read(1'b1, 16'd0, 1'b0, 24'd0, 1'b0, 1'b1);
        // largest gain and floor: floor alone saturates
        add_reg(CFG_VAR_GAIN, 24'h00FFFF);
        add_reg(CFG_VAR_FLOOR, 24'hFFFFFF);
        add_splat(9'd0, 8'd0, 16'h0001, 1'b1, 24'h000000, 1'b1, 16'd0, 16'd0);
        add_read(1'b1, 16'h0001, 1'b1, 24'hFFFFFF, 1'b1, 1'b1);
        add_splat(9'd0, 8'd0, 16'hFFFF, 1'b1, 24'hFFFFFF, 1'b1, 16'd0, 16'd0);
        add_read(1'b0, 16'd0, 1'b0, 24'd0, 1'b0, 1'b0);
        // oversize registers clamp to the maximum frame; far corners
        add_reg(CFG_FRAME_WIDTH, 24'h0001FF);
        add_reg(CFG_FRAME_HEIGHT, 24'h0000FF);
        add_splat(9'd319, 8'd0, 16'h4000, 1'b1, 24'h000100, 1'b1, 16'd0, 16'd0);
        add_splat(9'd0, 8'd239, 16'h5000, 1'b1, 24'h000200, 1'b0, 16'd0, 16'd0);
        add_splat(9'd511, 8'd255, 16'h0001, 1'b1, 24'h000300, 1'b1, -16'sd12288, -16'sd1024);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < plan.size(); i++) begin
            r = plan[i];
            case (r.kind)
                ROW_REG: begin
                    settle();
                    write_reg(r.reg_idx, r.reg_val);
                end
                ROW_READ: begin
                    read_notes.push_back(r.note);
                    push_word(CMD_READ, r.word);
                end
                default: begin
                    push_word(CMD_SPLAT, r.word);
                end
            endcase
        end

        // one full row and one full column reach the far edges of the store
        run_phase(9'd320, 8'd1, 16'($urandom), 24'($urandom_range(0, 16'hFFFF)), 400, 90);
        run_phase(9'd1, 8'd240, 16'd16384, 24'd0, 300, 90);
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: run_phase(9'($urandom_range(1, 8)), 8'($urandom_range(1, 6)),
                             16'd0, 24'd0, 70, 40);
                1: run_phase(9'($urandom_range(1, 8)), 8'($urandom_range(1, 6)),
                             16'hFFFF, 24'hFFFFFF, 70, 40);
                4: run_phase(9'($urandom_range(321, 511)), 8'($urandom_range(1, 2)),
                             16'($urandom), 24'($urandom), 70, 40);
                default: run_phase(9'($urandom_range(1, 8)), 8'($urandom_range(1, 6)),
                                   16'($urandom), 24'($urandom), 70, 40);
            endcase
        end
        settle();

        if (pending_pixels.size() != 0) begin
            $error("%0d pixels never came out", pending_pixels.size());
            fail_cnt++;
        end
        $display("%0d splat and %0d read words sent, %0d pixels checked, %0d frame ends",
                 splat_cnt, read_cnt, pixel_cnt, last_cnt);
        $display("frames from 1x1 to 320x240, depth ties, variance saturation, both-side stalls");
        if (fail_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/flzb_pkg.sv
rtl/core/flow_depth_splat_zbuffer.sv
verif/flow_depth_splat_zbuffer_tb.sv
